/* rtl/core/sipq_pkg.sv */
// shared types, constants and slot arithmetic for the sorted insert priority queue
package sipq_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 16;
    localparam int PAY_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_wr_req;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_rd_req;

    // circular slot of queue position pos, both operands below CAPACITY
    function automatic logic [IDX_W-1:0] slot_of(
        input logic [IDX_W-1:0] head,
        input logic [IDX_W-1:0] pos
    );
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (IDX_W + 1)'(CAPACITY)) begin
            sum = sum - (IDX_W + 1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

/* rtl/core/sipq_store.sv */
// entry memory: one write port, one read port, registered read data
module sipq_store
    import sipq_pkg::*;
(
    input  logic    i_clk,
    input  t_wr_req i_wr,
    input  t_rd_req i_rd,
    output t_entry  o_rd_data
);

    t_entry r_mem [CAPACITY];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/sorted_insert_priority_queue_top.sv */
// sorted insert priority queue: top level with control sequencer and output register
// dequeue passes ST_DEQ to ST_FIN; a refused transaction or an enqueue into an empty queue
// goes straight to ST_FIN; other enqueues shift each larger-key entry up in ST_SHIFT, then
// write the new entry (in ST_PLACE if all were larger); a result waits in ST_FIN while the
// output holds an unaccepted one; one transaction at a time, ready again once it is registered
// reset: synchronous active low, clears count, head slot and control; memory is not cleared
module sorted_insert_priority_queue_top
    import sipq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_op,
    input  logic [KEY_W-1:0]    i_entry_key,
    input  logic [PAY_W-1:0]    i_entry_payload,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [KEY_W-1:0]    o_out_key,
    output logic [PAY_W-1:0]    o_out_payload,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_entry_count
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SHIFT = 5'b00010,
        ST_PLACE = 5'b00100,
        ST_DEQ   = 5'b01000,
        ST_FIN   = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    t_entry            r_new, n_new;
    t_entry            r_fin, n_fin;
    t_status           r_fin_status, n_fin_status;

    logic              r_out_valid, n_out_valid;
    t_entry            r_out, n_out;
    t_status           r_out_status, n_out_status;
    logic [CNT_W-1:0]  r_out_count, n_out_count;

    t_wr_req           wr;
    t_rd_req           rd;
    t_entry            rd_data;
    logic              out_free;
    logic              full;
    logic              empty;

    sipq_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd      (rd),
        .o_rd_data (rd_data)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign empty      = (r_count == '0);
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_head       = r_head;
        n_count      = r_count;
        n_new        = r_new;
        n_fin        = r_fin;
        n_fin_status = r_fin_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        wr           = '0;
        rd           = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_new.key     = i_entry_key;
                    n_new.payload = i_entry_payload;
                    n_fin         = '0;
                    n_fin_status  = STS_OK;
                    if (i_op == OP_DEQ) begin
                        if (empty) begin
                            n_fin_status = STS_EMPTY;
                            n_state      = ST_FIN;
                        end else begin
                            rd.en   = 1'b1;
                            rd.addr = r_head;
                            n_state = ST_DEQ;
                        end
                    end else if (full) begin
                        n_fin_status = STS_FULL;
                        n_state      = ST_FIN;
                    end else if (empty) begin
                        n_head               = '0;
                        wr.en                = 1'b1;
                        wr.addr              = '0;
                        wr.data.key          = i_entry_key;
                        wr.data.payload      = i_entry_payload;
                        n_count              = CNT_W'(1);
                        n_state              = ST_FIN;
                    end else begin
                        rd.en   = 1'b1;
                        rd.addr = slot_of(r_head, r_count[IDX_W-1:0] - IDX_W'(1));
                        n_pos   = r_count[IDX_W-1:0];
                        n_state = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                wr.en   = 1'b1;
                wr.addr = slot_of(r_head, r_pos);
                if (r_new.key < rd_data.key) begin
                    wr.data = rd_data;
                    if (r_pos == IDX_W'(1)) begin
                        n_pos   = '0;
                        n_state = ST_PLACE;
                    end else begin
                        rd.en   = 1'b1;
                        rd.addr = slot_of(r_head, r_pos - IDX_W'(2));
                        n_pos   = r_pos - IDX_W'(1);
                    end
                end else begin
                    wr.data = r_new;
                    n_count = r_count + CNT_W'(1);
                    n_state = ST_FIN;
                end
            end
            ST_PLACE: begin
                wr.en   = 1'b1;
                wr.addr = r_head;
                wr.data = r_new;
                n_count = r_count + CNT_W'(1);
                n_state = ST_FIN;
            end
            ST_DEQ: begin
                n_fin   = rd_data;
                n_head  = slot_of(r_head, IDX_W'(1));
                n_count = r_count - CNT_W'(1);
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_fin;
                    n_out_status = r_fin_status;
                    n_out_count  = r_count;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_new        <= n_new;
        r_fin        <= n_fin;
        r_fin_status <= n_fin_status;
        r_out        <= n_out;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_key     = r_out.key;
    assign o_out_payload = r_out.payload;
    assign o_status      = r_out_status;
    assign o_entry_count = COUNT_W'(r_out_count);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_shift_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT) |-> (r_pos != '0))
        else $error("shift step at queue position zero");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != STS_OK) |-> (r_out == '0))
        else $error("refused transaction carries nonzero entry");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != ST_IDLE))
        else $error("sequencer idle right after accepting a transaction");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && out_free) |=> (o_entry_count == COUNT_W'($past(r_count))))
        else $error("reported count differs from held count");
`endif

endmodule

/* dv/sorted_insert_priority_queue_top_tb.sv */
// self-checking testbench for the sorted insert priority queue top level
module sorted_insert_priority_queue_top_tb;
    import sipq_pkg::*;

    localparam int TOTAL_TARGET = 1600;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic             hold;
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_queue_req;

    typedef struct {
        logic [KEY_W-1:0]   key;
        logic [PAY_W-1:0]   payload;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_queue_resp;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic                i_op = OP_ENQ;
    logic [KEY_W-1:0]    i_entry_key = '0;
    logic [PAY_W-1:0]    i_entry_payload = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [KEY_W-1:0]    o_out_key;
    logic [PAY_W-1:0]    o_out_payload;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_entry_count;

    t_queue_req  pending_reqs[$];
    t_queue_resp expected_resps[$];

    // shadow copy of the sorted store
    logic [KEY_W-1:0] shadow_keys     [CAPACITY];
    logic [PAY_W-1:0] shadow_payloads [CAPACITY];
    int unsigned      shadow_head = 0;
    int unsigned      shadow_count = 0;

    int unsigned accepted_reqs = 0;
    int unsigned total_reqs = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned stall_cycles = 0;
    int unsigned gen_count = 0;

    sorted_insert_priority_queue_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_entry_key     (i_entry_key),
        .i_entry_payload (i_entry_payload),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_key       (o_out_key),
        .o_out_payload   (o_out_payload),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned ring_slot(int unsigned pos);
        return (shadow_head + pos) % CAPACITY;
    endfunction

    function automatic t_queue_resp sorted_queue_apply(t_op op, logic [KEY_W-1:0] key,
                                                       logic [PAY_W-1:0] payload);
        t_queue_resp resp;
        int unsigned pos;
        resp.key = '0;
        resp.payload = '0;
        resp.status = STS_OK;
        if (op == OP_ENQ) begin
            if (shadow_count >= CAPACITY) begin
                resp.status = STS_FULL;
            end else begin
                if (shadow_count == 0) begin
                    shadow_head = 0;
                end
                pos = shadow_count;
                while (pos > 0 && key < shadow_keys[ring_slot(pos - 1)]) begin
                    shadow_keys[ring_slot(pos)] = shadow_keys[ring_slot(pos - 1)];
                    shadow_payloads[ring_slot(pos)] = shadow_payloads[ring_slot(pos - 1)];
                    pos--;
                end
                shadow_keys[ring_slot(pos)] = key;
                shadow_payloads[ring_slot(pos)] = payload;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                resp.status = STS_EMPTY;
            end else begin
                resp.key = shadow_keys[ring_slot(0)];
                resp.payload = shadow_payloads[ring_slot(0)];
                shadow_head = (shadow_head + 1) % CAPACITY;
                shadow_count--;
            end
        end
        resp.count = COUNT_W'(shadow_count);
        return resp;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    task automatic add_req(t_op op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] payload);
        t_queue_req req;
        req.hold = 1'b0;
        req.op = op;
        req.key = key;
        req.payload = payload;
        pending_reqs.push_back(req);
        total_reqs++;
        if (op == OP_ENQ && gen_count < CAPACITY) begin
            gen_count++;
        end else if (op == OP_DEQ && gen_count > 0) begin
            gen_count--;
        end
    endtask

    task automatic add_hold();
        t_queue_req req;
        req.hold = 1'b1;
        req.op = OP_ENQ;
        req.key = '0;
        req.payload = '0;
        pending_reqs.push_back(req);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(int mode);
        logic [KEY_W-1:0] k;
        case (mode)
            0: k = KEY_W'($urandom);
            1: k = KEY_W'($urandom_range(7));
            default: begin
                case ($urandom_range(3))
                    0: k = '0;
                    1: k = '1;
                    2: k = 16'h7fff;
                    default: k = 16'h8000;
                endcase
            end
        endcase
        return k;
    endfunction

    task automatic build_stimulus();
        int seg;
        int mode;
        int len;
        int enq_pct;
        bit first;
        // directed: empty refusal, extremes, equal keys, head reset to slot zero when an empty queue is refilled
        add_req(OP_DEQ, 16'h0000, 16'h0000);
        add_req(OP_ENQ, 16'h8000, 16'h0001);
        add_req(OP_ENQ, 16'hffff, 16'hffff);
        add_req(OP_ENQ, 16'h0000, 16'h0000);
        add_req(OP_ENQ, 16'h8000, 16'h0002);
        add_req(OP_ENQ, 16'h8000, 16'h0003);
        add_req(OP_ENQ, 16'hffff, 16'haaaa);
        repeat (6) add_req(OP_DEQ, 16'hffff, 16'hffff);
        add_req(OP_DEQ, 16'h5a5a, 16'ha5a5);
        add_req(OP_ENQ, 16'h1234, 16'h5555);
        add_req(OP_DEQ, 16'h0000, 16'h0000);
        add_hold();
        first = 1'b1;
        while (total_reqs < TOTAL_TARGET) begin
            seg = first ? 0 : $urandom_range(9);
            mode = $urandom_range(2);
            first = 1'b0;
            if (seg <= 1) begin
                while (gen_count < CAPACITY) begin
                    add_req(OP_ENQ, pick_key(mode), PAY_W'($urandom));
                end
                repeat ($urandom_range(3, 1)) add_req(OP_ENQ, pick_key(mode), PAY_W'($urandom));
            end else if (seg <= 3) begin
                while (gen_count > 0) begin
                    add_req(OP_DEQ, KEY_W'($urandom), PAY_W'($urandom));
                end
                repeat ($urandom_range(3, 1)) add_req(OP_DEQ, KEY_W'($urandom), PAY_W'($urandom));
            end else begin
                len = $urandom_range(40, 8);
                enq_pct = $urandom_range(70, 30);
                repeat (len) begin
                    if ($urandom_range(99) < enq_pct) begin
                        add_req(OP_ENQ, pick_key(mode), PAY_W'($urandom));
                    end else begin
                        add_req(OP_DEQ, KEY_W'($urandom), PAY_W'($urandom));
                    end
                end
            end
            if ($urandom_range(7) == 0) begin
                add_hold();
            end
        end
    endtask

    function automatic int unsigned idle_pct(bit sender);
        int unsigned phase;
        phase = (total_reqs == 0) ? 0 : (accepted_reqs * 3) / total_reqs;
        case (phase)
            0: return sender ? 18 : 84;
            1: return sender ? 84 : 18;
            default: return 0;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_queue_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_resps.push_back(sorted_queue_apply(t_op'(i_op), i_entry_key,
                                                            i_entry_payload));
                accepted_reqs++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_reqs.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (pending_reqs[0].hold) begin
                    i_in_valid <= 1'b0;
                    if (expected_resps.size() == 0) begin
                        void'(pending_reqs.pop_front());
                    end
                end else if ($urandom_range(99) < idle_pct(1'b1)) begin
                    i_in_valid <= 1'b0;
                end else begin
                    nxt = pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    i_op <= nxt.op;
                    i_entry_key <= nxt.key;
                    i_entry_payload <= nxt.payload;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_queue_resp want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_resps.size() == 0) begin
                    report_mismatch($sformatf("unexpected result key %h payload %h status %0d",
                                              o_out_key, o_out_payload, o_status));
                end else begin
                    want = expected_resps.pop_front();
                    if (o_out_key !== want.key || o_out_payload !== want.payload ||
                        o_status !== want.status || o_entry_count !== want.count) begin
                        report_mismatch($sformatf(
                            "got key %h payload %h status %0d count %0d, want %h %h %0d %0d",
                            o_out_key, o_out_payload, o_status, o_entry_count,
                            want.key, want.payload, want.status, want.count));
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        build_stimulus();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_reqs.size() != 0 || i_in_valid || expected_resps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_resps.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sorted_insert_priority_queue_top.f */
rtl/core/sipq_pkg.sv
rtl/core/sipq_store.sv
rtl/core/sorted_insert_priority_queue_top.sv
dv/sorted_insert_priority_queue_top_tb.sv
